FILE: hw/rtl/gbs_pkg.sv
// Shared constants, codes and types of the graph beam search core.
`default_nettype none
package gbs_pkg;

  localparam int NODES      = 32;
  localparam int MAX_DEGREE = 8;
  localparam int BEAM_MAX   = 8;
  localparam int MAX_DEPTH  = 32;

  localparam int PATH_LEN   = MAX_DEPTH + 1;
  localparam int CHILD_MAX  = BEAM_MAX * MAX_DEGREE;

  localparam int KIND_W     = 2;
  localparam int FIELD_NW   = 5;
  localparam int WEIGHT_W   = 8;
  localparam int EST_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int COST_W     = 13;
  localparam int F_W        = COST_W + 1;
  localparam int BW_W       = 4;
  localparam int LIM_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int NODE_W     = $clog2(NODES);
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int EIDX_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ADJ_AW     = NODE_W + EIDX_W;
  localparam int BEAM_IW    = (BEAM_MAX > 1) ? $clog2(BEAM_MAX) : 1;
  localparam int CNT_W      = $clog2(BEAM_MAX + 1);
  localparam int CHILD_IW   = (CHILD_MAX > 1) ? $clog2(CHILD_MAX) : 1;
  localparam int CHILD_CW   = $clog2(CHILD_MAX + 1);
  localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
  localparam int POS_W      = $clog2(PATH_LEN);
  localparam int CP_W       = $clog2(PATH_LEN + 1);
  localparam int PATH_AW    = 1 + BEAM_IW + POS_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEUR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PATH   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPATH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BEAM_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS = 2'd1;

  typedef struct packed {
    logic [NODE_W-1:0]  target;
    logic [WEIGHT_W-1:0] weight;
  } adj_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [COST_W-1:0]  cost;
    logic [BEAM_IW-1:0] parent;
    logic [F_W-1:0]     f;
  } child_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gbs_in_if.sv
// Input item channel of the graph beam search core.
`default_nettype none
interface gbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [gbs_pkg::KIND_W-1:0]    kind;
  logic [gbs_pkg::FIELD_NW-1:0]  node;
  logic [gbs_pkg::FIELD_NW-1:0]  neighbor;
  logic [gbs_pkg::WEIGHT_W-1:0]  edge_cost;
  logic [gbs_pkg::EST_W-1:0]     heuristic;
  logic [gbs_pkg::FIELD_NW-1:0]  start_node;
  logic [gbs_pkg::FIELD_NW-1:0]  goal_node;
  modport source (output valid, kind, node, neighbor, edge_cost, heuristic,
                  start_node, goal_node, input ready);
  modport sink (input valid, kind, node, neighbor, edge_cost, heuristic,
                start_node, goal_node, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gbs_out_if.sv
// Result channel of the graph beam search core.
`default_nettype none
interface gbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbs_pkg::STATUS_W-1:0]  status;
  logic [gbs_pkg::FIELD_NW-1:0]  path_node;
  logic [gbs_pkg::COST_W-1:0]    path_cost;
  logic                          last;
  modport source (output valid, status, path_node, path_cost, last, input ready);
  modport sink (input valid, status, path_node, path_cost, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gbs_cfg_if.sv
// Configuration write channel of the graph beam search core.
`default_nettype none
interface gbs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gbs_pkg::CFG_IDX_W-1:0]   index;
  logic [gbs_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/graph_beam_search_core.sv
// Top level of the graph beam search core: loader, level sequencer and ranking scan.
// Edge and heuristic items each give one result beat. A search item runs level by
// level: a goal test over the beam, expansion with an adjacency RAM read and then a
// child buffer write per child, and ranking as one pass over the child buffer per kept
// state, followed by a pick and a copy of the parent's path, with the new node, into
// the other bank. A found path then goes out one node per beat, each node read from
// the path store before its beat is loaded. The block takes no new item while a search runs.
`default_nettype none
module graph_beam_search_core (
  input  wire logic  clk,
  input  wire logic  rst,
  gbs_in_if.sink     item,
  gbs_out_if.source  result,
  gbs_cfg_if.sink    cfg
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_EXP_RD  = 4'd2;
  localparam logic [3:0] S_EXP_WR  = 4'd3;
  localparam logic [3:0] S_SEL     = 4'd4;
  localparam logic [3:0] S_PICK    = 4'd5;
  localparam logic [3:0] S_COPY    = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_WR = 4'd8;
  localparam logic [3:0] S_NOPATH  = 4'd9;

  logic [3:0] state;

  logic [gbs_pkg::BW_W-1:0]  beam_width;
  logic [gbs_pkg::LIM_W-1:0] max_levels;

  logic [gbs_pkg::DEG_W-1:0]  degree   [gbs_pkg::NODES];
  logic [gbs_pkg::EST_W-1:0]  estimate [gbs_pkg::NODES];
  logic [gbs_pkg::NODE_W-1:0] beam_node [gbs_pkg::BEAM_MAX];
  logic [gbs_pkg::COST_W-1:0] beam_cost [gbs_pkg::BEAM_MAX];
  logic [gbs_pkg::CHILD_MAX-1:0] picked;

  logic [gbs_pkg::CNT_W-1:0]    beam_count, bw_eff, bi, sel_k;
  logic [gbs_pkg::LVL_W-1:0]    level, lim, emit_k;
  logic                         bank;
  logic [gbs_pkg::NODE_W-1:0]   goal;
  logic [gbs_pkg::DEG_W-1:0]    ei;
  logic [gbs_pkg::CHILD_CW-1:0] nchild, scan_j;
  logic                         have;
  logic [gbs_pkg::CHILD_IW-1:0] best_idx;
  logic [gbs_pkg::F_W-1:0]      best_f;
  logic [gbs_pkg::NODE_W-1:0]   best_node;
  logic [gbs_pkg::COST_W-1:0]   best_cost;
  logic [gbs_pkg::BEAM_IW-1:0]  best_parent, emit_idx;
  logic [gbs_pkg::CP_W-1:0]     cp;

  logic                          ov, o_last;
  logic [gbs_pkg::STATUS_W-1:0]  o_status;
  logic [gbs_pkg::NODE_W-1:0]    o_node;
  logic [gbs_pkg::COST_W-1:0]    o_cost;

  logic out_free, accept;
  assign out_free   = !ov || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign accept     = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid     = ov;
  assign result.status    = o_status;
  assign result.path_node = gbs_pkg::FIELD_NW'(o_node);
  assign result.path_cost = o_cost;
  assign result.last      = o_last;

  logic [gbs_pkg::NODE_W-1:0] in_node, in_nbr, in_start, in_goal;
  assign in_node  = item.node[gbs_pkg::NODE_W-1:0];
  assign in_nbr   = item.neighbor[gbs_pkg::NODE_W-1:0];
  assign in_start = item.start_node[gbs_pkg::NODE_W-1:0];
  assign in_goal  = item.goal_node[gbs_pkg::NODE_W-1:0];

  logic [gbs_pkg::DEG_W-1:0] in_deg;
  logic                      in_full;
  assign in_deg  = degree[in_node];
  assign in_full = in_deg >= gbs_pkg::DEG_W'(gbs_pkg::MAX_DEGREE);

  logic [gbs_pkg::CNT_W-1:0] bw_cap;
  logic [gbs_pkg::LVL_W-1:0] lim_cap;
  assign bw_cap  = (beam_width > gbs_pkg::BW_W'(gbs_pkg::BEAM_MAX)) ?
                   gbs_pkg::CNT_W'(gbs_pkg::BEAM_MAX) : gbs_pkg::CNT_W'(beam_width);
  assign lim_cap = (max_levels > gbs_pkg::LIM_W'(gbs_pkg::MAX_DEPTH)) ?
                   gbs_pkg::LVL_W'(gbs_pkg::MAX_DEPTH) : gbs_pkg::LVL_W'(max_levels);

  // a result beat is loaded into the output register this cycle
  logic load_beat;
  assign load_beat = ((state == S_IDLE) && accept &&
                      !(item.kind == gbs_pkg::KIND_SEARCH && bw_cap != '0)) ||
                     ((state == S_EMIT_WR || state == S_NOPATH) && out_free);

  // goal test, best rank first
  logic                        found;
  logic [gbs_pkg::BEAM_IW-1:0] found_idx;
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < gbs_pkg::BEAM_MAX; i++) begin
      if (!found && (gbs_pkg::CNT_W'(i) < beam_count) && (beam_node[i] == goal)) begin
        found     = 1'b1;
        found_idx = gbs_pkg::BEAM_IW'(i);
      end
    end
  end

  // expansion datapath
  logic [gbs_pkg::BEAM_IW-1:0] bsel;
  logic [gbs_pkg::NODE_W-1:0]  cur_node;
  logic [gbs_pkg::DEG_W-1:0]   cur_deg;
  assign bsel     = bi[gbs_pkg::BEAM_IW-1:0];
  assign cur_node = beam_node[bsel];
  assign cur_deg  = degree[cur_node];

  gbs_pkg::adj_t adj_wdata, adj_rdata;
  logic          adj_we;
  assign adj_we    = accept && (item.kind == gbs_pkg::KIND_EDGE) && !in_full;
  assign adj_wdata = '{target: in_nbr, weight: item.edge_cost};

  gbs_ram #(.WIDTH($bits(gbs_pkg::adj_t)), .DEPTH(gbs_pkg::NODES * gbs_pkg::MAX_DEGREE))
    u_adj (
      .clk   (clk),
      .we    (adj_we),
      .waddr ({in_node, in_deg[gbs_pkg::EIDX_W-1:0]}),
      .wdata (adj_wdata),
      .raddr ({cur_node, ei[gbs_pkg::EIDX_W-1:0]}),
      .rdata (adj_rdata)
    );

  logic [gbs_pkg::F_W-1:0]    sum;
  logic [gbs_pkg::COST_W-1:0] child_c;
  gbs_pkg::child_t            child_w, child_r;
  assign sum     = {1'b0, beam_cost[bsel]} + gbs_pkg::F_W'(adj_rdata.weight);
  assign child_c = (sum > gbs_pkg::F_W'(gbs_pkg::COST_MAX)) ?
                   gbs_pkg::COST_MAX : sum[gbs_pkg::COST_W-1:0];
  assign child_w = '{node:   adj_rdata.target,
                     cost:   child_c,
                     parent: bsel,
                     f:      {1'b0, child_c} + gbs_pkg::F_W'(estimate[adj_rdata.target])};

  gbs_ram #(.WIDTH($bits(gbs_pkg::child_t)), .DEPTH(gbs_pkg::CHILD_MAX))
    u_child (
      .clk   (clk),
      .we    (state == S_EXP_WR),
      .waddr (nchild[gbs_pkg::CHILD_IW-1:0]),
      .wdata (child_w),
      .raddr (scan_j[gbs_pkg::CHILD_IW-1:0]),
      .rdata (child_r)
    );

  logic [gbs_pkg::CHILD_CW-1:0] pj;
  logic                         better;
  assign pj     = scan_j - 1'b1;
  assign better = (scan_j != '0) && !picked[pj[gbs_pkg::CHILD_IW-1:0]] &&
                  (!have || (child_r.f < best_f));

  // path store: two banks, swapped each level
  logic [gbs_pkg::CP_W-1:0]      lvl_cp;
  logic                          path_we;
  logic [gbs_pkg::PATH_AW-1:0]   path_waddr, path_raddr;
  logic [gbs_pkg::NODE_W-1:0]    path_wdata, path_rdata;
  assign lvl_cp = gbs_pkg::CP_W'(level);

  always_comb begin
    path_we    = 1'b0;
    path_waddr = {bank, best_parent, gbs_pkg::POS_W'(0)};
    path_wdata = path_rdata;
    if (state == S_EMIT_RD || state == S_EMIT_WR) begin
      path_raddr = {bank, emit_idx, gbs_pkg::POS_W'(emit_k)};
    end else begin
      path_raddr = {bank, best_parent, cp[gbs_pkg::POS_W-1:0]};
    end
    if (accept && item.kind == gbs_pkg::KIND_SEARCH) begin
      path_we    = 1'b1;
      path_waddr = '0;
      path_wdata = in_start;
    end else if (state == S_COPY && cp != '0) begin
      path_we = 1'b1;
      if (cp == lvl_cp + 2'd2) begin
        path_waddr = {~bank, sel_k[gbs_pkg::BEAM_IW-1:0], gbs_pkg::POS_W'(lvl_cp + 1'b1)};
        path_wdata = best_node;
      end else begin
        path_waddr = {~bank, sel_k[gbs_pkg::BEAM_IW-1:0], gbs_pkg::POS_W'(cp - 1'b1)};
      end
    end
  end

  gbs_ram #(.WIDTH(gbs_pkg::NODE_W), .DEPTH(2 * gbs_pkg::BEAM_MAX * (2 ** gbs_pkg::POS_W)))
    u_path (
      .clk   (clk),
      .we    (path_we),
      .waddr (path_waddr),
      .wdata (path_wdata),
      .raddr (path_raddr),
      .rdata (path_rdata)
    );

  logic [gbs_pkg::CNT_W-1:0] k_inc;
  logic                      emit_fin;
  assign k_inc    = sel_k + 1'b1;
  assign emit_fin = (emit_k == level);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      beam_width <= gbs_pkg::BW_W'(2);
      max_levels <= gbs_pkg::LIM_W'(32);
      ov         <= 1'b0;
      beam_count <= '0;
      for (int n = 0; n < gbs_pkg::NODES; n++) begin
        degree[n]   <= '0;
        estimate[n] <= '0;
      end
    end else begin
      if (load_beat) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          gbs_pkg::REG_BEAM_WIDTH: beam_width <= cfg.data[gbs_pkg::BW_W-1:0];
          gbs_pkg::REG_MAX_LEVELS: max_levels <= cfg.data[gbs_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_node <= '0;
            o_cost <= '0;
            o_last <= 1'b1;
            case (item.kind)
              gbs_pkg::KIND_EDGE: begin
                o_status <= in_full ? gbs_pkg::ST_FULL : gbs_pkg::ST_OK;
                if (!in_full) degree[in_node] <= in_deg + 1'b1;
              end
              gbs_pkg::KIND_HEUR: begin
                o_status          <= gbs_pkg::ST_OK;
                estimate[in_node] <= item.heuristic;
              end
              gbs_pkg::KIND_SEARCH: begin
                if (bw_cap == '0) begin
                  o_status <= gbs_pkg::ST_NOPATH;
                end else begin
                  beam_node[0] <= in_start;
                  beam_cost[0] <= '0;
                  beam_count   <= gbs_pkg::CNT_W'(1);
                  bank         <= 1'b0;
                  level        <= '0;
                  goal         <= in_goal;
                  bw_eff       <= bw_cap;
                  lim          <= lim_cap;
                  state        <= S_CHECK;
                end
              end
              default: begin
                o_status <= gbs_pkg::ST_OK;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (found) begin
            emit_idx <= found_idx;
            emit_k   <= '0;
            state    <= S_EMIT_RD;
          end else if (level >= lim) begin
            state <= S_NOPATH;
          end else begin
            bi     <= '0;
            ei     <= '0;
            nchild <= '0;
            state  <= S_EXP_RD;
          end
        end
        S_EXP_RD: begin
          if (bi == beam_count) begin
            picked <= '0;
            sel_k  <= '0;
            scan_j <= '0;
            have   <= 1'b0;
            state  <= (nchild == '0) ? S_NOPATH : S_SEL;
          end else if (ei < cur_deg) begin
            state <= S_EXP_WR;
          end else begin
            bi <= bi + 1'b1;
            ei <= '0;
          end
        end
        S_EXP_WR: begin
          nchild <= nchild + 1'b1;
          ei     <= ei + 1'b1;
          state  <= S_EXP_RD;
        end
        S_SEL: begin
          if (better) begin
            have        <= 1'b1;
            best_idx    <= pj[gbs_pkg::CHILD_IW-1:0];
            best_f      <= child_r.f;
            best_node   <= child_r.node;
            best_cost   <= child_r.cost;
            best_parent <= child_r.parent;
          end
          if (scan_j == nchild) begin
            state <= S_PICK;
          end else begin
            scan_j <= scan_j + 1'b1;
          end
        end
        S_PICK: begin
          picked[best_idx]                       <= 1'b1;
          beam_node[sel_k[gbs_pkg::BEAM_IW-1:0]] <= best_node;
          beam_cost[sel_k[gbs_pkg::BEAM_IW-1:0]] <= best_cost;
          cp                                     <= '0;
          state                                  <= S_COPY;
        end
        S_COPY: begin
          if (cp == lvl_cp + 2'd2) begin
            sel_k <= k_inc;
            if (k_inc < bw_eff && gbs_pkg::CHILD_CW'(k_inc) < nchild) begin
              scan_j <= '0;
              have   <= 1'b0;
              state  <= S_SEL;
            end else begin
              beam_count <= k_inc;
              bank       <= ~bank;
              level      <= level + 1'b1;
              state      <= S_CHECK;
            end
          end else begin
            cp <= cp + 1'b1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_free) begin
            o_status <= gbs_pkg::ST_PATH;
            o_node   <= path_rdata;
            o_cost   <= emit_fin ? beam_cost[emit_idx] : '0;
            o_last   <= emit_fin;
            if (emit_fin) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + 1'b1;
              state  <= S_EMIT_RD;
            end
          end
        end
        S_NOPATH: begin
          if (out_free) begin
            o_status <= gbs_pkg::ST_NOPATH;
            o_node   <= '0;
            o_cost   <= '0;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_beam_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (beam_count != '0 &&
                            beam_count <= gbs_pkg::CNT_W'(gbs_pkg::BEAM_MAX)))
    else $error("beam count out of range at goal test");

  a_child_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP_WR) |-> (nchild < gbs_pkg::CHILD_CW'(gbs_pkg::CHILD_MAX)))
    else $error("child buffer overrun");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WR) |-> (emit_k <= level))
    else $error("path beat beyond current level");

  a_degree_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP_RD && bi != beam_count) |->
      (cur_deg <= gbs_pkg::DEG_W'(gbs_pkg::MAX_DEGREE)))
    else $error("adjacency degree above limit");

  a_pick_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (have && !picked[best_idx]))
    else $error("ranking picked an empty or used child");

endmodule
`default_nettype wire

FILE: hw/rtl/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
